/* hdl/keq_pkg.sv */
// shared types and constants for the keypad event qualifier
package keq_pkg;

    localparam int MAX_COLUMNS  = 4;
    localparam int KEY_W        = 32;
    localparam int KEY_IDX_W    = 5;
    localparam int RESULT_LIMIT = 36;
    localparam int CNT_W        = 6;
    localparam int COLS_W       = 3;
    localparam int ROWS_W       = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    // effective column limit: the smaller of the build limit and four bytes
    localparam logic [COLS_W-1:0] COLS_CAP =
        COLS_W'((MAX_COLUMNS < 4) ? MAX_COLUMNS : 4);
    localparam logic [ROWS_W-1:0] ROWS_CAP = ROWS_W'(8);

    typedef enum logic [2:0] {
        EV_KEY_PRESS    = 3'd0,
        EV_KEY_RELEASE  = 3'd1,
        EV_PROG_PRESS   = 3'd2,
        EV_PROG_RELEASE = 3'd3,
        EV_LOCK         = 3'd4,
        EV_LIGHT        = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        LT_BLUE   = 3'd0,
        LT_RED    = 3'd1,
        LT_FLASH  = 3'd2,
        LT_KEEP   = 3'd3,
        LT_ROWS   = 3'd4
    } light_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_COLUMNS = 2'd0,
        REG_ROWS_IN_USE    = 2'd1,
        REG_IGNORE_MASK    = 2'd2,
        REG_CRITICAL_MASK  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic             prog_switch;
        logic [KEY_W-1:0] key_bits;
    } report_t;

    typedef struct packed {
        kind_t                event_kind;
        logic [KEY_IDX_W-1:0] key_index;
        light_t               light_cmd;
        logic                 locked_now;
        logic                 last_of_run;
    } result_t;

endpackage

/* hdl/keypad_event_qualifier.sv */
// keypad event qualifier: bit-serial key scan, event sequencing and output register
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+-------------------------------
//  in        | in        | in_valid / in_stall | report_t (prog level, key bits)
//  out       | out       | out_valid/out_stall | result_t (one event)
//  cfg       | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  one report passes these steps before the next can be taken: rest to take it, the
//  program switch, the press scan (a key that displaces a pending critical key is
//  looked at again), the release scan, the lock toggle and the flush of the final
//  event.
//  the scan looks at one key bit per cycle while the output register lets it run.
//  a stalled output register holds the engine until the event moves on.
//  reset clears key history, lock flag, pending key and masks; geometry is 4 x 8.
module keypad_event_qualifier (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  keq_pkg::report_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output keq_pkg::result_t                    out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [keq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [keq_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import keq_pkg::*;

    // one-hot sequencer
    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_PROG    = 6'b000010,
        ST_PRESS   = 6'b000100,
        ST_RELEASE = 6'b001000,
        ST_LOCK    = 6'b010000,
        ST_FLUSH   = 6'b100000
    } state_t;

    // configuration
    logic [COLS_W-1:0]    cols_reg;
    logic [ROWS_W-1:0]    rows_reg;
    logic [KEY_W-1:0]     ignore_reg;
    logic [KEY_W-1:0]     critical_reg;

    // persistent state
    logic [KEY_W-1:0]     prev_keys_reg;   // rotates once per press scan
    logic                 prev_prog_reg;
    logic                 lock_reg;
    logic                 pend_v_reg;
    logic [KEY_IDX_W-1:0] pend_k_reg;

    // per-report working registers
    state_t               state_reg;
    logic [KEY_IDX_W-1:0] k_reg;
    logic [KEY_W-1:0]     cur_sr_reg;
    logic [KEY_W-1:0]     ign_sr_reg;
    logic [KEY_W-1:0]     crit_sr_reg;
    logic [KEY_W-1:0]     off_sr_reg;
    logic                 prog_l_reg;
    logic                 prog_rel_reg;
    logic                 was_locked_reg;
    logic [CNT_W-1:0]     cnt_reg;

    // one-deep hold so the final event of a report can be marked
    logic                 hold_v_reg;
    result_t              hold_reg;

    // output register
    logic                 out_v_reg;
    result_t              out_reg;

    // combinational scan and event logic
    logic [COLS_W-1:0]    cols_eff;
    logic [ROWS_W-1:0]    rows_eff;
    logic                 scanned;
    logic                 row_ok;
    logic                 cb;
    logic                 pb;
    logic                 on_b;
    logic                 off_b;
    logic                 nb;
    logic                 displace;
    logic                 gen;
    result_t              gen_res;
    result_t              push_res;
    logic                 take;
    logic                 can_push;
    logic                 go;
    logic                 push;
    logic                 accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    // clamp geometry; user keeps config steady while a report is in work, unenforced
    assign cols_eff = (cols_reg > COLS_CAP) ? COLS_CAP : cols_reg;
    assign rows_eff = (rows_reg > ROWS_CAP) ? ROWS_CAP : rows_reg;

    // key k sits in bit zero of every shifting word
    assign scanned = ({1'b0, k_reg[KEY_IDX_W-1:3]} < cols_eff);
    assign row_ok  = ({1'b0, k_reg[2:0]} < rows_eff);
    assign cb      = cur_sr_reg[0];
    assign pb      = prev_keys_reg[0];
    assign on_b    = scanned && row_ok && !ign_sr_reg[0] && !was_locked_reg && cb && !pb;
    assign off_b   = scanned && row_ok && !ign_sr_reg[0] && !cb && pb;
    // locked: stored levels may only clear
    assign nb      = scanned ? (was_locked_reg ? (pb && cb) : cb) : pb;
    // a new press knocks out a different pending key first
    assign displace = on_b && pend_v_reg && (pend_k_reg != k_reg);

    assign can_push = !out_v_reg || !out_stall;

    always_comb
    begin
        gen     = 1'b0;
        gen_res = '{event_kind: EV_LIGHT, key_index: '0, light_cmd: LT_KEEP,
                    locked_now: lock_reg, last_of_run: 1'b0};
        case (state_reg)
            ST_PROG:
            begin
                gen = (prog_l_reg != prev_prog_reg);
                gen_res.event_kind = prog_l_reg ? EV_PROG_PRESS : EV_PROG_RELEASE;
            end
            ST_PRESS:
            begin
                gen = on_b;
                if (displace)
                begin
                    gen_res.event_kind = EV_LIGHT;
                    gen_res.key_index  = pend_k_reg;
                    gen_res.light_cmd  = LT_BLUE;
                end
                else if ((pend_v_reg && pend_k_reg == k_reg) || !crit_sr_reg[0])
                begin
                    gen_res.event_kind = EV_KEY_PRESS;
                    gen_res.key_index  = k_reg;
                    gen_res.light_cmd  = LT_RED;
                end
                else
                begin
                    gen_res.event_kind = EV_LIGHT;
                    gen_res.key_index  = k_reg;
                    gen_res.light_cmd  = LT_FLASH;
                end
            end
            ST_RELEASE:
            begin
                // releasing the pending key says nothing
                gen = off_sr_reg[0] && !(pend_v_reg && pend_k_reg == k_reg);
                gen_res.event_kind = EV_KEY_RELEASE;
                gen_res.key_index  = k_reg;
                gen_res.light_cmd  = was_locked_reg ? LT_KEEP : LT_BLUE;
            end
            ST_LOCK:
            begin
                gen = prog_rel_reg;
                gen_res.event_kind = EV_LOCK;
                gen_res.light_cmd  = LT_ROWS;
                gen_res.locked_now = !lock_reg;
            end
            default:
            begin
                gen = 1'b0;
            end
        endcase
    end

    // held event on its way out, marked as final when it leaves from the flush step
    always_comb
    begin
        push_res             = hold_reg;
        push_res.last_of_run = (state_reg == ST_FLUSH);
    end

    // past the limit events are dropped but the scan still updates state
    assign take = gen && (cnt_reg < CNT_W'(RESULT_LIMIT));
    assign go   = (state_reg == ST_FLUSH) ? (!hold_v_reg || can_push)
                                          : (!take || !hold_v_reg || can_push);
    assign push = hold_v_reg && can_push &&
                  ((state_reg == ST_FLUSH) || take);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg     <= COLS_W'(4);
            rows_reg     <= ROWS_W'(8);
            ignore_reg   <= '0;
            critical_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_ACTIVE_COLUMNS: cols_reg     <= cfg_data[COLS_W-1:0];
                REG_ROWS_IN_USE:    rows_reg     <= cfg_data[ROWS_W-1:0];
                REG_IGNORE_MASK:    ignore_reg   <= cfg_data[KEY_W-1:0];
                REG_CRITICAL_MASK:  critical_reg <= cfg_data[KEY_W-1:0];
                default:            cols_reg     <= cols_reg;
            endcase
        end
    end

    // sequencer and key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            k_reg          <= '0;
            prev_keys_reg  <= '0;
            prev_prog_reg  <= 1'b0;
            lock_reg       <= 1'b0;
            pend_v_reg     <= 1'b0;
            pend_k_reg     <= '0;
            prog_l_reg     <= 1'b0;
            prog_rel_reg   <= 1'b0;
            was_locked_reg <= 1'b0;
            cnt_reg        <= '0;
            hold_v_reg     <= 1'b0;
        end
        else
        begin
            if (take && go)
            begin
                hold_v_reg <= 1'b1;
                cnt_reg    <= cnt_reg + CNT_W'(1);
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        prog_l_reg     <= in_data.prog_switch;
                        was_locked_reg <= lock_reg;
                        cnt_reg        <= '0;
                        k_reg          <= '0;
                        state_reg      <= ST_PROG;
                    end
                end
                ST_PROG:
                begin
                    if (go)
                    begin
                        prog_rel_reg  <= (prog_l_reg != prev_prog_reg) && !prog_l_reg;
                        prev_prog_reg <= prog_l_reg;
                        state_reg     <= ST_PRESS;
                    end
                end
                ST_PRESS:
                begin
                    if (go)
                    begin
                        if (displace)
                        begin
                            // same key again next cycle, now with nothing pending
                            pend_v_reg <= 1'b0;
                            pend_k_reg <= '0;
                        end
                        else
                        begin
                            prev_keys_reg <= {nb, prev_keys_reg[KEY_W-1:1]};
                            if (on_b)
                            begin
                                if ((pend_v_reg && pend_k_reg == k_reg) || !crit_sr_reg[0])
                                begin
                                    pend_v_reg <= 1'b0;
                                    pend_k_reg <= '0;
                                end
                                else
                                begin
                                    pend_v_reg <= 1'b1;
                                    pend_k_reg <= k_reg;
                                end
                            end
                            k_reg <= k_reg + KEY_IDX_W'(1);
                            if (&k_reg)
                            begin
                                state_reg <= ST_RELEASE;
                            end
                        end
                    end
                end
                ST_RELEASE:
                begin
                    if (go)
                    begin
                        k_reg <= k_reg + KEY_IDX_W'(1);
                        if (&k_reg)
                        begin
                            state_reg <= ST_LOCK;
                        end
                    end
                end
                ST_LOCK:
                begin
                    if (go)
                    begin
                        if (prog_rel_reg)
                        begin
                            pend_v_reg <= 1'b0;
                            pend_k_reg <= '0;
                            lock_reg   <= !lock_reg;
                        end
                        state_reg <= ST_FLUSH;
                    end
                end
                ST_FLUSH:
                begin
                    if (go)
                    begin
                        hold_v_reg <= 1'b0;
                        state_reg  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // shifting words for the serial scan; payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_sr_reg  <= in_data.key_bits;
            ign_sr_reg  <= ignore_reg;
            crit_sr_reg <= critical_reg;
        end
        else if (state_reg == ST_PRESS && go && !displace)
        begin
            cur_sr_reg  <= {1'b0, cur_sr_reg[KEY_W-1:1]};
            ign_sr_reg  <= {1'b0, ign_sr_reg[KEY_W-1:1]};
            crit_sr_reg <= {1'b0, crit_sr_reg[KEY_W-1:1]};
        end

        // release bits gathered in the press scan, replayed in the release scan
        if (state_reg == ST_PRESS && go && !displace)
        begin
            off_sr_reg <= {off_b, off_sr_reg[KEY_W-1:1]};
        end
        else if (state_reg == ST_RELEASE && go)
        begin
            off_sr_reg <= {1'b0, off_sr_reg[KEY_W-1:1]};
        end

        if (take && go)
        begin
            hold_reg <= gen_res;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (push)
        begin
            out_v_reg <= 1'b1;
        end
        else if (out_v_reg && !out_stall)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_reg <= push_res;
        end
    end

    // checks

    // no event may linger in the hold once the sequencer is back at rest
    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hold_v_reg)
        else $error("hold slot occupied while idle");

    // event count never passes the per-report limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(RESULT_LIMIT))
        else $error("event count above limit");

    // a transfer on the input starts the program switch step
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_PROG))
        else $error("report accepted but sequencer not started");

    // the flushed event is the final one of its report
    a_flush_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && hold_v_reg && can_push)
            |=> (out_v_reg && out_reg.last_of_run))
        else $error("final event not marked");

endmodule
